/* hdl/frf_pkg.sv */
`timescale 1ns / 1ps

package frf_pkg;

	// Ring geometry; the depth must stay a power of two so that the low
	// counter bits address the store directly.
	localparam int RING_DEPTH   = 64;
	localparam int PAYLOAD_BITS = 64;

	localparam int ADDR_W    = $clog2(RING_DEPTH);
	localparam int FILL_W    = $clog2(RING_DEPTH + 1);
	localparam int CNT_W     = 32;
	localparam int PAYLOAD_W = 64;

	typedef enum logic {
		REQ_PUSH = 1'b0,
		REQ_POP  = 1'b1
	} req_type_t;

	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [FILL_W-1:0]       fill_t;
	typedef logic [ADDR_W-1:0]       addr_t;
	typedef logic [PAYLOAD_BITS-1:0] entry_t;

endpackage

/* hdl/frf_if.sv */
`timescale 1ns / 1ps

interface frf_req_if;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [frf_pkg::PAYLOAD_W-1:0] push_payload;

	modport source (output valid, output req_type, output push_payload, input ready);
	modport sink   (input valid, input req_type, input push_payload, output ready);
endinterface

interface frf_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          ok;
	logic [frf_pkg::PAYLOAD_W-1:0] pop_payload;
	logic [frf_pkg::CNT_W-1:0]     pop_capture_seq;
	logic [frf_pkg::FILL_W-1:0]    fill_level;
	logic [frf_pkg::CNT_W-1:0]     drops;
	logic [frf_pkg::FILL_W-1:0]    peak_fill;

	modport source (output valid, output ok, output pop_payload, output pop_capture_seq,
		output fill_level, output drops, output peak_fill, input ready);
	modport sink   (input valid, input ok, input pop_payload, input pop_capture_seq,
		input fill_level, input drops, input peak_fill, output ready);
endinterface

/* hdl/frame_ring_fifo_with_drop_stats.sv */
`timescale 1ns / 1ps

// Responses are registered, valid the cycle after acceptance. Throughput: one
// request per cycle unless responses stall; the store has one write and one
// registered read port, and the response register doubles as the read stage.
// Reset (arst_n, async low) clears counters, header_valid and the response
// valid; the frame store is not cleared and needs no clearing pass.
module frame_ring_fifo_with_drop_stats (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic         cfg_wr_data,
	frf_req_if.sink      req,
	frf_rsp_if.source    rsp
);

	frf_pkg::entry_t frame_mem [frf_pkg::RING_DEPTH];

	frf_pkg::cnt_t  wr_cnt_q;
	frf_pkg::cnt_t  rd_cnt_q;
	frf_pkg::cnt_t  drop_q;
	frf_pkg::fill_t peak_q;
	logic           hdr_valid_q;

	logic            valid_s1;
	logic            ok_s1;
	logic            pop_ok_s1;
	frf_pkg::cnt_t   seq_s1;
	frf_pkg::fill_t  fill_s1;
	frf_pkg::cnt_t   drops_s1;
	frf_pkg::fill_t  peak_s1;
	frf_pkg::entry_t rd_data_s1;

	logic           accept;
	logic           is_pop;
	logic           full;
	logic           empty;
	logic           push_ok;
	logic           push_drop;
	logic           pop_ok;
	frf_pkg::fill_t fill_cur;
	frf_pkg::fill_t fill_push;
	frf_pkg::cnt_t  wr_cnt_nxt;
	frf_pkg::cnt_t  rd_cnt_nxt;
	frf_pkg::cnt_t  drop_nxt;
	frf_pkg::fill_t peak_nxt;
	frf_pkg::fill_t fill_nxt;

	assign req.ready = !valid_s1 || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_pop    = (req.req_type == frf_pkg::REQ_POP);

	// Occupancy never exceeds the depth, so the low bits of the difference hold it.
	assign fill_cur  = frf_pkg::FILL_W'(wr_cnt_q - rd_cnt_q);
	assign full      = (fill_cur == frf_pkg::FILL_W'(frf_pkg::RING_DEPTH));
	assign empty     = (wr_cnt_q == rd_cnt_q);
	assign fill_push = fill_cur + frf_pkg::FILL_W'(1);

	assign push_ok   = hdr_valid_q && !is_pop && !full;
	assign push_drop = hdr_valid_q && !is_pop && full;
	assign pop_ok    = hdr_valid_q && is_pop && !empty;

	always_comb begin
		wr_cnt_nxt = push_ok ? wr_cnt_q + frf_pkg::CNT_W'(1) : wr_cnt_q;
		rd_cnt_nxt = pop_ok ? rd_cnt_q + frf_pkg::CNT_W'(1) : rd_cnt_q;
		drop_nxt   = push_drop ? drop_q + frf_pkg::CNT_W'(1) : drop_q;
		peak_nxt   = (push_ok && fill_push > peak_q) ? fill_push : peak_q;
		fill_nxt   = frf_pkg::FILL_W'(wr_cnt_nxt - rd_cnt_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_valid_q <= 1'b0;
		end else if (cfg_wr_en) begin
			hdr_valid_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_cnt_q <= '0;
			rd_cnt_q <= '0;
			drop_q   <= '0;
			peak_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				wr_cnt_q <= wr_cnt_nxt;
				rd_cnt_q <= rd_cnt_nxt;
				drop_q   <= drop_nxt;
				peak_q   <= peak_nxt;
				valid_s1 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Response fields; hold while the consumer stalls.
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1     <= push_ok || pop_ok;
			pop_ok_s1 <= pop_ok;
			seq_s1    <= rd_cnt_q + frf_pkg::CNT_W'(1);
			fill_s1   <= fill_nxt;
			drops_s1  <= drop_nxt;
			peak_s1   <= peak_nxt;
		end
	end

	// Frame store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (accept && push_ok) begin
			frame_mem[frf_pkg::addr_t'(wr_cnt_q[frf_pkg::ADDR_W-1:0])] <=
				req.push_payload[frf_pkg::PAYLOAD_BITS-1:0];
		end
		if (accept && pop_ok) begin
			rd_data_s1 <= frame_mem[frf_pkg::addr_t'(rd_cnt_q[frf_pkg::ADDR_W-1:0])];
		end
	end

	assign rsp.valid           = valid_s1;
	assign rsp.ok              = ok_s1;
	assign rsp.pop_payload     = pop_ok_s1 ? frf_pkg::PAYLOAD_W'(rd_data_s1) : '0;
	assign rsp.pop_capture_seq = pop_ok_s1 ? seq_s1 : '0;
	assign rsp.fill_level      = fill_s1;
	assign rsp.drops           = drops_s1;
	assign rsp.peak_fill       = peak_s1;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_cur <= frf_pkg::FILL_W'(frf_pkg::RING_DEPTH))
		else $error("ring occupancy above depth");

	a_peak_covers_fill: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= fill_cur)
		else $error("high-water mark below current fill");

	a_pop_advance: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pop_ok |=> rd_cnt_q == $past(rd_cnt_q) + frf_pkg::CNT_W'(1))
		else $error("read counter did not advance on pop");

	a_drop_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && push_drop |=> drop_q == $past(drop_q) + frf_pkg::CNT_W'(1)
			&& wr_cnt_q == $past(wr_cnt_q))
		else $error("refused push not counted as drop");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !rsp.ready |=> valid_s1 && $stable(fill_s1) && $stable(drops_s1))
		else $error("stalled response lost");
`endif

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
	import frf_pkg::*;

	typedef struct packed {
		logic                 ok;
		logic [PAYLOAD_W-1:0] pop_payload;
		cnt_t                 seq;
		fill_t                fill;
		cnt_t                 drops;
		fill_t                peak;
	} ring_reply_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;

	frf_req_if req();
	frf_rsp_if rsp();

	frame_ring_fifo_with_drop_stats uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req),
		.rsp         (rsp)
	);

	// Local copy of the ring state
	entry_t model_frames [RING_DEPTH];
	cnt_t   model_wr_cnt    = '0;
	cnt_t   model_rd_cnt    = '0;
	cnt_t   model_drops     = '0;
	fill_t  model_high      = '0;
	logic   model_hdr_valid = 1'b0;

	ring_reply_t owed_replies [$];
	int unsigned mismatches    = 0;
	int unsigned snd_idle_pct  = 0;
	int unsigned rcv_idle_pct  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	function automatic ring_reply_t ring_apply(req_type_t kind, entry_t payload);
		ring_reply_t r;
		cnt_t        used;
		r = '0;
		if (model_hdr_valid) begin
			used = model_wr_cnt - model_rd_cnt;
			if (kind == REQ_PUSH) begin
				if (used >= RING_DEPTH) begin
					model_drops = model_drops + 1;
				end else begin
					model_frames[model_wr_cnt[ADDR_W-1:0]] = payload;
					model_wr_cnt = model_wr_cnt + 1;
					if (used + 1 > model_high)
						model_high = fill_t'(used + 1);
					r.ok = 1'b1;
				end
			end else if (model_rd_cnt != model_wr_cnt) begin
				r.pop_payload = model_frames[model_rd_cnt[ADDR_W-1:0]];
				r.seq = model_rd_cnt + 1;
				model_rd_cnt = model_rd_cnt + 1;
				r.ok = 1'b1;
			end
		end
		used = model_wr_cnt - model_rd_cnt;
		r.fill  = (used > RING_DEPTH) ? fill_t'(RING_DEPTH) : fill_t'(used);
		r.drops = model_drops;
		r.peak  = model_high;
		return r;
	endfunction

	function automatic void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			mismatches++;
		end
	endfunction

	// Check the response transaction first, then predict the request taken at this edge
	always @(posedge clk) begin
		ring_reply_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (owed_replies.size() == 0) begin
					$error("response transaction with no request outstanding");
					mismatches++;
				end else begin
					want = owed_replies.pop_front();
					check_field("ok", want.ok, rsp.ok);
					check_field("pop_payload", want.pop_payload, rsp.pop_payload);
					check_field("pop_capture_seq", want.seq, rsp.pop_capture_seq);
					check_field("fill_level", want.fill, rsp.fill_level);
					check_field("drops", want.drops, rsp.drops);
					check_field("peak_fill", want.peak, rsp.peak_fill);
				end
			end
			if (cfg_wr_en)
				model_hdr_valid = cfg_wr_data;
			if (req.valid && req.ready)
				owed_replies.push_back(ring_apply(req_type_t'(req.req_type),
					entry_t'(req.push_payload)));
		end
	end

	always @(negedge clk) begin
		rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	// Hold valid until accepted, then idle the sender at random
	task automatic send_request(input req_type_t kind, input logic [PAYLOAD_W-1:0] payload);
		req.valid        = 1'b1;
		req.req_type     = kind;
		req.push_payload = payload;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		while ($urandom_range(99) < snd_idle_pct) begin
			req.valid = 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic wait_drained();
		req.valid = 1'b0;
		while (owed_replies.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_header(input logic value);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
	endtask

	// Header still invalid after reset: everything fails, nothing is counted
	task automatic test_header_invalid();
		send_request(REQ_PUSH, '0);
		send_request(REQ_POP, '0);
		send_request(REQ_PUSH, '1);
		wait_drained();
	endtask

	task automatic test_payload_extremes();
		send_request(REQ_POP, '1);
		send_request(REQ_PUSH, '0);
		send_request(REQ_PUSH, '1);
		send_request(REQ_PUSH, 64'h5555_5555_5555_5555);
		send_request(REQ_PUSH, 64'hAAAA_AAAA_AAAA_AAAA);
		repeat (4) send_request(REQ_POP, 64'h0123_4567_89AB_CDEF);
		send_request(REQ_POP, '0);
		wait_drained();
	endtask

	// Drop the header with frames in the ring; state must survive untouched
	task automatic test_header_gate();
		send_request(REQ_PUSH, 64'hDEAD_BEEF_0000_0001);
		send_request(REQ_PUSH, 64'hDEAD_BEEF_0000_0002);
		wait_drained();
		write_header(1'b0);
		send_request(REQ_POP, '0);
		send_request(REQ_PUSH, '1);
		wait_drained();
		write_header(1'b1);
		repeat (3) send_request(REQ_POP, '0);
		wait_drained();
	endtask

	task automatic test_full_ring();
		repeat (RING_DEPTH + 3) send_request(REQ_PUSH, {$urandom, $urandom});
		repeat (RING_DEPTH + 1) send_request(REQ_POP, {$urandom, $urandom});
		wait_drained();
	endtask

	// Bursts biased toward push or pop so the fill sweeps between empty and full
	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned sent;
		int unsigned burst;
		int unsigned push_pct;
		logic [PAYLOAD_W-1:0] payload;
		sent = 0;
		while (sent < n_items) begin
			burst = $urandom_range(120, 8);
			case ($urandom_range(2))
				0: begin
					push_pct = 15;
				end
				1: begin
					push_pct = 50;
				end
				default: begin
					push_pct = 85;
				end
			endcase
			for (int unsigned i = 0; i < burst && sent < n_items; i++) begin
				case ($urandom_range(15))
					0: payload = '0;
					1: payload = '1;
					default: payload = {$urandom, $urandom};
				endcase
				send_request(($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_POP, payload);
				sent++;
			end
		end
		wait_drained();
	endtask

	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_wr_data      = 1'b0;
		req.valid        = 1'b0;
		req.req_type     = REQ_PUSH;
		req.push_payload = '0;
		rsp.ready        = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		snd_idle_pct = 16;
		rcv_idle_pct = 79;
		test_header_invalid();
		write_header(1'b1);
		test_payload_extremes();
		test_header_gate();
		test_full_ring();
		test_random_traffic(330);

		snd_idle_pct = 79;
		rcv_idle_pct = 16;
		write_header(1'b0);
		test_random_traffic(20);
		write_header(1'b1);
		test_random_traffic(330);

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_full_ring();
		test_random_traffic(280);

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* files.f */
hdl/frf_pkg.sv
hdl/frf_if.sv
hdl/frame_ring_fifo_with_drop_stats.sv
bench/tb.sv
